// ----- design/ghash_pkg.sv -----
package ghash_pkg;

  // field and block widths
  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned AAD_LEN_W   = 61;
  localparam int unsigned TEXT_LEN_W  = 36;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned STEP_W      = 4;

  // function codes
  localparam logic [1:0] FUNC_AAD   = 2'd0;
  localparam logic [1:0] FUNC_TEXT  = 2'd1;
  localparam logic [1:0] FUNC_FINAL = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_AAD_LATE = 2'd1;
  localparam logic [1:0] STATUS_LIMIT    = 2'd2;

  // configuration register indexes
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // reduction constant, top byte of the 128-bit pattern
  localparam logic [DIGIT_W-1:0] RED_POLY = 8'hE1;

  // text limit in octets (2^39 - 256 bits)
  localparam logic [TEXT_LEN_W:0] TEXT_MAX_OCTETS = 37'h0F_FFFF_FFE0;

  // full residual block
  localparam logic [COUNT_W-1:0] FULL_COUNT = 5'd16;

  // multiplier controls
  typedef struct packed {
    logic start;
    logic clear;
  } mul_ctrl_t;

  // packer controls
  typedef struct packed {
    logic               clear;
    logic               shift;
    logic [DIGIT_W-1:0] din;
  } pack_ctrl_t;

  // multiply by x in the bit-reflected field
  function automatic logic [BLOCK_W-1:0] gf_mul_x(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r[BLOCK_W-1 -: DIGIT_W] = r[BLOCK_W-1 -: DIGIT_W] ^ RED_POLY;
    end
    return r;
  endfunction

endpackage

// ----- design/ghash_packer.sv -----
module ghash_packer
  import ghash_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  pack_ctrl_t          ctrl,
  output logic [BLOCK_W-1:0]  block,
  output logic [COUNT_W-1:0]  count,
  output logic                full
);

  logic [BLOCK_W-1:0] residual;

  // residual bytes shift in at the low end, first byte ends on top
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      residual <= {residual[BLOCK_W-DIGIT_W-1:0], ctrl.din};
    end
  end

  // byte count
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
    end else if (ctrl.shift) begin
      count <= count + COUNT_W'(1);
    end
  end

  assign block = residual;
  assign full  = (count == FULL_COUNT);

endmodule

// ----- design/ghash_gf_mult.sv -----
module ghash_gf_mult
  import ghash_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mul_ctrl_t           ctrl,
  input  logic [BLOCK_W-1:0]  block,
  input  logic [BLOCK_W-1:0]  key,
  output logic [BLOCK_W-1:0]  acc,
  output logic                done
);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [BLOCK_W-1:0] z;
  logic [BLOCK_W-1:0] v;
  logic [BLOCK_W-1:0] hk;
  logic [BLOCK_W-1:0] z_next;
  logic [BLOCK_W-1:0] v_next;

  // one key digit per cycle, most significant bit first
  always_comb begin
    z_next = z;
    v_next = v;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (hk[BLOCK_W-1-j]) begin
        z_next = z_next ^ v_next;
      end
      v_next = gf_mul_x(v_next);
    end
  end

  assign done = busy && (step == {STEP_W{1'b1}});

  // sequence control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      acc  <= '0;
    end else if (ctrl.clear) begin
      busy <= 1'b0;
      step <= '0;
      acc  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (done) begin
        busy <= 1'b0;
        acc  <= z_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      z  <= '0;
      v  <= acc ^ block;
      hk <= key;
    end else if (busy) begin
      z  <= z_next;
      v  <= v_next;
      hk <= hk << DIGIT_W;
    end
  end

endmodule

// ----- design/ghash_authenticator_unit.sv -----
// operation: an item's bytes shift through the packer one by one, and each block that they complete
// is multiplied into the accumulator before the item goes on
// finalize pads a partial block to full and then multiplies in the lengths block; the first text item of a
// message first pads a partial aad block the same way; a stalled result holds the unit
// items are taken one at a time, the pace set by the byte-wide packer and the 8-bit-per-cycle
// gf(2^128) multiplier; reset: synchronous rst clears the key, the accumulator, the lengths and the output valid
module ghash_authenticator_unit
  import ghash_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  // input channel
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   func,
  input  logic [63:0]  data_high,
  input  logic [63:0]  data_low,
  input  logic [4:0]   byte_count,
  // output channel
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   status,
  output logic         tag_valid,
  output logic [63:0]  tag_high,
  output logic [63:0]  tag_low
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FLUSH,
    S_BYTES,
    S_MULT,
    S_LENS,
    S_DONE
  } state_t;

  state_t               state;
  logic [63:0]          key_high;
  logic [63:0]          key_low;
  logic [AAD_LEN_W-1:0] aad_octets;
  logic [TEXT_LEN_W-1:0] text_octets;
  logic                 aad_done;
  logic                 flush_pending;
  logic                 lens_pending;
  logic                 final_pending;
  logic [COUNT_W-1:0]   bytes_left;
  logic [BLOCK_W-1:0]   data_sr;
  logic [1:0]           status_hold;

  logic                 in_xfer;
  logic                 out_free;
  logic [COUNT_W-1:0]   n;
  logic [AAD_LEN_W:0]   aad_sum;
  logic [TEXT_LEN_W:0]  text_sum;
  logic                 aad_ovf;
  logic                 text_ovf;
  logic [BLOCK_W-1:0]   lens_block;
  logic [BLOCK_W-1:0]   mul_block;
  logic [BLOCK_W-1:0]   acc;
  logic                 mul_done;
  mul_ctrl_t            mul_ctrl;
  pack_ctrl_t           pack_ctrl;
  logic [BLOCK_W-1:0]   pack_block;
  logic [COUNT_W-1:0]   pack_count;
  logic                 pack_full;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // byte count saturates at a full block
  assign n = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;

  // length limit checks
  assign aad_sum  = {1'b0, aad_octets} + (AAD_LEN_W+1)'(n);
  assign aad_ovf  = aad_sum[AAD_LEN_W];
  assign text_sum = {1'b0, text_octets} + (TEXT_LEN_W+1)'(n);
  assign text_ovf = (text_sum > TEXT_MAX_OCTETS);

  // bit lengths block
  assign lens_block = {aad_octets, 3'b000, 25'd0, text_octets, 3'b000};
  assign mul_block  = (state == S_LENS) ? lens_block : pack_block;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default:      key_high <= key_high;
      endcase
    end
  end

  // unit controls
  always_comb begin
    mul_ctrl       = '0;
    pack_ctrl      = '0;
    pack_ctrl.din  = data_sr[BLOCK_W-1 -: DIGIT_W];
    case (state)
      S_FLUSH: begin
        pack_ctrl.din = '0;
        if (pack_full) begin
          mul_ctrl.start  = 1'b1;
          pack_ctrl.clear = 1'b1;
        end else begin
          pack_ctrl.shift = 1'b1;
        end
      end
      S_BYTES: begin
        if (pack_full) begin
          mul_ctrl.start  = 1'b1;
          pack_ctrl.clear = 1'b1;
        end else if (bytes_left != '0) begin
          pack_ctrl.shift = 1'b1;
        end
      end
      S_LENS: begin
        mul_ctrl.start = 1'b1;
      end
      S_DONE: begin
        if (out_free && final_pending) begin
          mul_ctrl.clear  = 1'b1;
          pack_ctrl.clear = 1'b1;
        end
      end
      default: begin
        mul_ctrl.start = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      aad_octets    <= '0;
      text_octets   <= '0;
      aad_done      <= 1'b0;
      flush_pending <= 1'b0;
      lens_pending  <= 1'b0;
      final_pending <= 1'b0;
      bytes_left    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // result transfer frees the register unless a new result loads it
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            data_sr       <= {data_high, data_low};
            lens_pending  <= (func == FUNC_FINAL);
            final_pending <= (func == FUNC_FINAL);
            state         <= S_DISPATCH;
            case (func)
              FUNC_AAD: begin
                flush_pending <= 1'b0;
                if (aad_done) begin
                  status_hold <= STATUS_AAD_LATE;
                  bytes_left  <= '0;
                end else if (aad_ovf) begin
                  status_hold <= STATUS_LIMIT;
                  bytes_left  <= '0;
                end else begin
                  status_hold <= STATUS_OK;
                  bytes_left  <= n;
                  aad_octets  <= aad_sum[AAD_LEN_W-1:0];
                end
              end
              FUNC_TEXT: begin
                // first text item closes the aad part
                flush_pending <= !aad_done;
                aad_done      <= 1'b1;
                if (text_ovf) begin
                  status_hold <= STATUS_LIMIT;
                  bytes_left  <= '0;
                end else begin
                  status_hold <= STATUS_OK;
                  bytes_left  <= n;
                  text_octets <= text_sum[TEXT_LEN_W-1:0];
                end
              end
              FUNC_FINAL: begin
                flush_pending <= 1'b1;
                status_hold   <= STATUS_OK;
                bytes_left    <= '0;
              end
              default: begin
                flush_pending <= 1'b0;
                status_hold   <= STATUS_OK;
                bytes_left    <= '0;
              end
            endcase
          end
        end
        S_DISPATCH: begin
          if (flush_pending) begin
            flush_pending <= 1'b0;
            if (pack_count != '0) begin
              state <= S_FLUSH;
            end
          end else if (bytes_left != '0) begin
            state <= S_BYTES;
          end else if (lens_pending) begin
            state <= S_LENS;
          end else begin
            state <= S_DONE;
          end
        end
        S_FLUSH: begin
          if (pack_full) begin
            state <= S_MULT;
          end
        end
        S_BYTES: begin
          if (pack_full) begin
            state <= S_MULT;
          end else if (bytes_left != '0) begin
            data_sr    <= data_sr << DIGIT_W;
            bytes_left <= bytes_left - COUNT_W'(1);
          end else begin
            state <= S_DISPATCH;
          end
        end
        S_MULT: begin
          if (mul_done) begin
            state <= S_DISPATCH;
          end
        end
        S_LENS: begin
          lens_pending <= 1'b0;
          state        <= S_MULT;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= status_hold;
            tag_valid <= final_pending;
            tag_high  <= final_pending ? acc[BLOCK_W-1 -: 64] : 64'd0;
            tag_low   <= final_pending ? acc[63:0] : 64'd0;
            if (final_pending) begin
              aad_octets    <= '0;
              text_octets   <= '0;
              aad_done      <= 1'b0;
              final_pending <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ghash_packer u_packer (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (pack_ctrl),
    .block (pack_block),
    .count (pack_count),
    .full  (pack_full)
  );

  ghash_gf_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mul_ctrl),
    .block (mul_block),
    .key   ({key_high, key_low}),
    .acc   (acc),
    .done  (mul_done)
  );

endmodule
